[hdl/bswr_pkg.sv]
package bswr_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REVERSE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_POP_WORD = -32'sd999;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_REV_HI,
        S_REV_WLO,
        S_REV_WHI
    } t_state;

endpackage

[hdl/bounded_stack_with_reverse.sv]
// Push, refused push, empty pop, reverse of fewer than two entries and the unused
// action: result in the cycle after the transaction is accepted, busy stays low.
// Pop: busy in S_POP for one memory read; the result is registered after S_POP.
// Reverse of n >= 2 entries: busy through floor(n/2) swaps, two reads and two writes
// per swap on the simple dual-port entry memory; result in the cycle after.
// Synchronous active-low reset empties the stack; memory contents are not cleared.
module bounded_stack_with_reverse
    import bswr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [WORD_W-1:0]   i_push_value,
    output logic                       o_valid,
    output logic signed [WORD_W-1:0]   o_pop_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] r_mem [DEPTH];

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_lo, n_lo;
    logic [AW-1:0] r_hi, n_hi;
    logic [WORD_W-1:0] r_tmp, n_tmp;
    logic [WORD_W-1:0] r_rd_data;
    logic r_valid, n_valid;
    logic signed [WORD_W-1:0] r_value, n_value;
    logic [STATUS_W-1:0] r_status, n_status;

    logic rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic accept;
    logic is_full, is_empty, has_pair, more_swaps;
    logic [CW-1:0] count_m1;

    assign accept     = i_start && (r_state == S_IDLE);
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign has_pair   = ({1'b0, r_count} >= (CW + 1)'(2));
    assign count_m1   = r_count - 1'b1;
    // another swap remains when lo+1 < hi-1
    assign more_swaps = (({1'b0, r_hi} - {1'b0, r_lo}) > (AW + 1)'(2));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_POP && !is_empty) begin
                        n_state = S_POP;
                    end else if (i_action == ACT_REVERSE && has_pair) begin
                        n_state = S_REV_HI;
                    end
                end
            end
            S_POP:     n_state = S_IDLE;
            S_REV_HI:  n_state = S_REV_WLO;
            S_REV_WLO: n_state = S_REV_WHI;
            S_REV_WHI: n_state = more_swaps ? S_REV_HI : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_tmp    = r_tmp;
        n_valid  = 1'b0;
        n_value  = r_value;
        n_status = r_status;
        rd_en    = 1'b0;
        rd_addr  = r_lo;
        wr_en    = 1'b0;
        wr_addr  = r_lo;
        wr_data  = r_rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid  = 1'b1;
                    n_value  = '0;
                    n_status = ST_OK;
                    case (i_action)
                        ACT_PUSH: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                wr_data = i_push_value;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                                n_value  = EMPTY_POP_WORD;
                            end else begin
                                n_valid = 1'b0;
                                rd_en   = 1'b1;
                                rd_addr = count_m1[AW-1:0];
                                n_count = count_m1;
                            end
                        end
                        ACT_REVERSE: begin
                            if (has_pair) begin
                                n_valid = 1'b0;
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_lo    = '0;
                                n_hi    = count_m1[AW-1:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                n_valid  = 1'b1;
                n_value  = r_rd_data;
                n_status = ST_OK;
            end
            S_REV_HI: begin
                // hold the low word while the high one is fetched
                rd_en   = 1'b1;
                rd_addr = r_hi;
                n_tmp   = r_rd_data;
            end
            S_REV_WLO: begin
                wr_en   = 1'b1;
                wr_addr = r_lo;
                wr_data = r_rd_data;
            end
            S_REV_WHI: begin
                wr_en   = 1'b1;
                wr_addr = r_hi;
                wr_data = r_tmp;
                if (more_swaps) begin
                    rd_en   = 1'b1;
                    rd_addr = r_lo + 1'b1;
                    n_lo    = r_lo + 1'b1;
                    n_hi    = r_hi - 1'b1;
                end else begin
                    n_valid  = 1'b1;
                    n_value  = '0;
                    n_status = ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_tmp    <= n_tmp;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_pop_value   = r_value;
    assign o_status      = r_status;
    assign o_entry_count = COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_PUSH) |=> (o_valid && o_status != ST_EMPTY))
        else $error("push gave no result in the next cycle");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (o_valid && o_status == ST_OK))
        else $error("pop read gave no result");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && r_state != S_POP && !(r_state == S_REV_WHI && !more_swaps))
            |=> !o_valid)
        else $error("result strobe raised mid-transaction");

endmodule

[verif/testbench.sv]
module testbench;
    import bswr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1425;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 30;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [ACTION_W-1:0]      i_action;
    logic signed [WORD_W-1:0] i_push_value;
    logic                     o_valid;
    logic signed [WORD_W-1:0] o_pop_value;
    logic [STATUS_W-1:0]      o_status;
    logic [COUNT_W-1:0]       o_entry_count;

    bounded_stack_with_reverse #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

    // Mirror of the stack contents; one expected reply per accepted transaction.
    class lifo_tracker;
        typedef struct {
            logic signed [WORD_W-1:0] pop_value;
            logic [STATUS_W-1:0]      status;
            logic [COUNT_W-1:0]       entry_count;
        } reply_t;

        logic signed [WORD_W-1:0] words [STACK_DEPTH];
        int     fill;
        reply_t pending_replies [$];
        int     errors;
        int     n_push, n_pop, n_reverse, n_unused, n_full, n_empty, n_replies, peak_fill;

        function new();
            fill      = 0;
            errors    = 0;
            n_push    = 0;
            n_pop     = 0;
            n_reverse = 0;
            n_unused  = 0;
            n_full    = 0;
            n_empty   = 0;
            n_replies = 0;
            peak_fill = 0;
        endfunction

        function void note_command(logic [ACTION_W-1:0] act, logic signed [WORD_W-1:0] word);
            reply_t                   r;
            logic signed [WORD_W-1:0] tmp;
            int                       lo;
            int                       hi;
            r.pop_value = '0;
            r.status    = ST_OK;
            case (act)
                ACT_PUSH: begin
                    n_push++;
                    if (fill >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        words[fill] = word;
                        fill++;
                    end
                end
                ACT_POP: begin
                    n_pop++;
                    if (fill == 0) begin
                        r.status    = ST_EMPTY;
                        r.pop_value = EMPTY_POP_WORD;
                        n_empty++;
                    end else begin
                        fill--;
                        r.pop_value = words[fill];
                    end
                end
                ACT_REVERSE: begin
                    n_reverse++;
                    lo = 0;
                    hi = fill - 1;
                    while (lo < hi) begin
                        tmp       = words[lo];
                        words[lo] = words[hi];
                        words[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
                default: begin
                    n_unused++;
                end
            endcase
            if (fill > peak_fill) peak_fill = fill;
            r.entry_count = COUNT_W'(fill);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic signed [WORD_W-1:0] pop_value,
                                  logic [STATUS_W-1:0] status,
                                  logic [COUNT_W-1:0] entry_count);
            reply_t e;
            if (pending_replies.size() == 0) begin
                $error("result with no transaction outstanding: pop_value %0d status %0d count %0d",
                       pop_value, status, entry_count);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            n_replies++;
            if (pop_value !== e.pop_value) begin
                $error("pop_value: expected %0d, got %0d", e.pop_value, pop_value);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (entry_count !== e.entry_count) begin
                $error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
                errors++;
            end
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    lifo_tracker sb = new();
    int cycle_count = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Note accepted transactions before checking results seen at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_command(i_action, i_push_value);
            if (o_valid) sb.check_reply(o_pop_value, o_status, o_entry_count);
        end
    end

    // Hold the transaction until the edge at which it is taken.
    task automatic issue(input logic [ACTION_W-1:0] act, input logic signed [WORD_W-1:0] word);
        i_action     <= act;
        i_push_value <= word;
        i_start      <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
            3:       return EMPTY_POP_WORD;
            4:       return $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        int k;
        issue(ACT_POP, 32'sd5);
        issue(ACT_REVERSE, 32'sd0);
        issue(ACT_UNUSED, 32'sh7FFF_FFFF);
        issue(ACT_PUSH, 32'sh8000_0000);
        issue(ACT_REVERSE, -32'sd1);
        issue(ACT_PUSH, 32'sh7FFF_FFFF);
        issue(ACT_PUSH, -32'sd1);
        issue(ACT_PUSH, 32'sd0);
        issue(ACT_PUSH, EMPTY_POP_WORD);
        // Fill up to the last free slot.
        for (k = 5; k < STACK_DEPTH; k++) issue(ACT_PUSH, $urandom);
        issue(ACT_PUSH, 32'sh5A5A_A5A5);
        issue(ACT_REVERSE, 32'sd0);
        issue(ACT_UNUSED, 32'sd0);
        issue(ACT_POP, 32'sd0);
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int bias;
        int roll;
        int j;
        logic [ACTION_W-1:0] act;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            // Lean towards filling or draining so that both ends are reached often.
            bias = $urandom_range(0, 2);
            for (j = 0; j < burst && sent < count; j++) begin
                roll = $urandom_range(0, 99);
                case (bias)
                    0:       act = roll < 65 ? ACT_PUSH : roll < 85 ? ACT_POP :
                                   roll < 97 ? ACT_REVERSE : ACT_UNUSED;
                    1:       act = roll < 20 ? ACT_PUSH : roll < 85 ? ACT_POP :
                                   roll < 97 ? ACT_REVERSE : ACT_UNUSED;
                    default: act = roll < 45 ? ACT_PUSH : roll < 88 ? ACT_POP :
                                   roll < 97 ? ACT_REVERSE : ACT_UNUSED;
                endcase
                issue(act, pick_word());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_action     <= ACT_PUSH;
        i_push_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_ITEMS);
        i_start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions: %0d push, %0d pop, %0d reverse, %0d unused action",
                 sb.n_push + sb.n_pop + sb.n_reverse + sb.n_unused,
                 sb.n_push, sb.n_pop, sb.n_reverse, sb.n_unused);
        $display("%0d results checked, %0d refused pushes, %0d empty pops, peak depth %0d",
                 sb.n_replies, sb.n_full, sb.n_empty, sb.peak_fill);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
